### hw/rtl/ace_pkg.sv
// Shared constants for the ANC caption extractor.
package ace_pkg;

  localparam int TripleDepth = 31;
  localparam int TripleAw    = 5;

  localparam logic [1:0] StatusTriple  = 2'd0;
  localparam logic [1:0] StatusNone    = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  localparam logic [1:0] RegLineFirst  = 2'd0;
  localparam logic [1:0] RegLineSecond = 2'd1;
  localparam logic [1:0] RegDid        = 2'd2;
  localparam logic [1:0] RegSdid       = 2'd3;

  localparam logic [15:0] CdpIdent   = 16'h9669;
  localparam logic [7:0]  SecTimecode = 8'h71;
  localparam logic [7:0]  SecCcData   = 8'h72;
  localparam logic [7:0]  CcCountMask = 8'h1F;

endpackage

### hw/rtl/ace_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ace_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [Aw-1:0]    wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic [Aw-1:0]    rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/anc_caption_extractor_top.sv
// Top level: SMPTE-436M ANC byte parser with caption triple buffer.
// A status result is valid the cycle after the packet-end byte is taken; the first stored
// triple passes the read state (RAM read) and then the emit step (output register).
// Bytes are taken one per cycle while parsing and no result is waiting; stored triples
// drain one at a time, each held until out_ready, and no byte is taken during the drain.
// Reset (rst, synchronous) restores register defaults and the parser start state.
module anc_caption_extractor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        packet_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  cc_header,
  output logic [7:0]  cc_byte_one,
  output logic [7:0]  cc_byte_two,
  output logic        end_of_run
);
  import ace_pkg::*;

  typedef enum logic [3:0] {
    PH_COUNT_HI, PH_COUNT_LO, PH_HEADER, PH_VANC_HDR, PH_CDP_FIXED,
    PH_TC_SKIP, PH_CC_COUNT, PH_TRIPLES, PH_SKIP, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {MODE_PARSE, MODE_READ, MODE_EMIT} mode_t;

  // configuration registers
  logic [15:0] line_first, line_second;
  logic [7:0]  did, sdid;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_first  <= 16'd9;
      line_second <= 16'd11;
      did         <= 8'h61;
      sdid        <= 8'h01;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegLineFirst:  line_first  <= cfg_data;
        RegLineSecond: line_second <= cfg_data;
        RegDid:        did         <= cfg_data[7:0];
        RegSdid:       sdid        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // parser state
  phase_t      phase;
  logic [3:0]  offs;
  logic [15:0] pk_left;
  logic [31:0] ab_left;
  logic [7:0]  vb_left;
  logic [31:0] shift;
  logic [15:0] hline;
  logic [7:0]  hcoding;
  logic [4:0]  tcount;
  logic        captured, err;
  logic [23:0] tri_acc;

  phase_t      phase_next;
  logic [3:0]  offs_next;
  logic [15:0] pk_left_next;
  logic [31:0] ab_left_next;
  logic [7:0]  vb_left_next;
  logic [31:0] shift_next;
  logic [15:0] hline_next;
  logic [7:0]  hcoding_next;
  logic [4:0]  tcount_next;
  logic        captured_next, err_next;
  logic [23:0] tri_acc_next;
  logic        ram_we;

  mode_t       mode;
  logic [4:0]  rd_idx;
  logic [4:0]  drain_n;
  logic [23:0] rd_data;

  logic        take;
  assign in_ready = (mode == MODE_PARSE) && !out_valid;
  assign take     = in_valid && in_ready;

  // per-byte parse step
  always_comb begin
    logic [7:0]  b;
    logic [31:0] sh;
    logic [7:0]  cc;
    logic [9:0]  cc3;
    logic        is_pay;
    b = data_byte;
    phase_next = phase; offs_next = offs; pk_left_next = pk_left;
    ab_left_next = ab_left; vb_left_next = vb_left; shift_next = shift;
    hline_next = hline; hcoding_next = hcoding; tcount_next = tcount;
    captured_next = captured; err_next = err; tri_acc_next = tri_acc;
    ram_we = 1'b0;
    sh = '0; cc = '0; cc3 = '0;
    is_pay = 1'b0;
    case (phase)
      PH_COUNT_HI: begin
        shift_next = {24'd0, b};
        phase_next = PH_COUNT_LO;
      end
      PH_COUNT_LO: begin
        pk_left_next = {shift[7:0], b};
        if ({shift[7:0], b} == 16'd0) phase_next = PH_DONE;
        else begin
          phase_next = PH_HEADER; offs_next = '0; shift_next = '0;
        end
      end
      PH_HEADER: begin
        sh = {shift[23:0], b};
        shift_next = sh;
        if (offs == 4'd1) hline_next = sh[15:0];
        else if (offs == 4'd3) hcoding_next = b;
        else if (offs == 4'd9) ab_left_next = sh;
        if (offs >= 4'd13) begin
          if (sh != 32'd1 || hcoding < 8'd4 || hcoding > 8'd12) begin
            err_next = 1'b1; phase_next = PH_DONE;
          end else if ((hcoding >= 8'd7 && hcoding <= 8'd9) ||
                       (hline != line_first && hline != line_second)) begin
            if (ab_left == 32'd0) begin
              pk_left_next = pk_left - 16'd1;
              if (pk_left == 16'd1) phase_next = PH_DONE;
              else begin
                phase_next = PH_HEADER; offs_next = '0; shift_next = '0;
              end
            end else phase_next = PH_SKIP;
          end else if (ab_left == 32'd0) begin
            err_next = 1'b1; phase_next = PH_DONE;
          end else begin
            phase_next = PH_VANC_HDR; offs_next = '0; shift_next = '0;
          end
        end else offs_next = offs + 4'd1;
      end
      PH_DONE: ;
      default: is_pay = 1'b1;
    endcase

    if (is_pay) begin
      if (ab_left != 32'd0) ab_left_next = ab_left - 32'd1;
      if (phase inside {PH_CDP_FIXED, PH_TC_SKIP, PH_CC_COUNT, PH_TRIPLES} &&
          vb_left != 8'd0)
        vb_left_next = vb_left - 8'd1;
      case (phase)
        PH_VANC_HDR: begin
          if (offs == 4'd0) begin
            shift_next = {24'd0, b}; offs_next = 4'd1;
          end else if (offs == 4'd1) begin
            shift_next = {16'd0, shift[7:0], b}; offs_next = 4'd2;
          end else if (ab_left_next < ({24'd0, b} + 32'd4)) begin
            err_next = 1'b1; phase_next = PH_DONE;
          end else if (shift[15:8] != did || shift[7:0] != sdid) begin
            phase_next = PH_SKIP;
          end else if (b == 8'd0) begin
            err_next = 1'b1; phase_next = PH_DONE;
          end else begin
            vb_left_next = b; phase_next = PH_CDP_FIXED;
            offs_next = '0; shift_next = '0;
          end
        end
        PH_CDP_FIXED: begin
          if (offs == 4'd0) shift_next = {24'd0, b};
          else if (offs == 4'd1) begin
            shift_next = {16'd0, shift[7:0], b};
            if ({shift[7:0], b} != CdpIdent) begin
              err_next = 1'b1; phase_next = PH_DONE;
            end
          end else if (offs == 4'd7) begin
            if (b == SecTimecode) begin
              phase_next = PH_TC_SKIP; offs_next = '0;
            end else if (b == SecCcData) phase_next = PH_CC_COUNT;
            else phase_next = PH_SKIP;
          end
          if (phase_next == PH_CDP_FIXED) offs_next = offs + 4'd1;
        end
        PH_TC_SKIP: begin
          if (offs >= 4'd4) begin
            if (b == SecCcData) phase_next = PH_CC_COUNT;
            else phase_next = PH_SKIP;
          end else offs_next = offs + 4'd1;
        end
        PH_CC_COUNT: begin
          cc  = b & CcCountMask;
          cc3 = {2'd0, cc} + {1'b0, cc, 1'b0};
          if ({2'd0, vb_left_next} < cc3) begin
            err_next = 1'b1; phase_next = PH_DONE;
          end else if (cc == 8'd0) phase_next = PH_SKIP;
          else begin
            captured_next = 1'b1; tcount_next = '0; offs_next = '0;
            shift_next = {22'd0, cc3}; phase_next = PH_TRIPLES;
          end
        end
        PH_TRIPLES: begin
          // assemble a triple, write it when the third byte arrives and the buffer has room
          if (offs == 4'd0) tri_acc_next = {b, 16'd0};
          else if (offs == 4'd1) tri_acc_next = {tri_acc[23:16], b, 8'd0};
          else tri_acc_next = {tri_acc[23:8], b};
          if (offs >= 4'd2) begin
            offs_next = '0;
            if (tcount < 5'(TripleDepth)) begin
              ram_we = 1'b1;
              tcount_next = tcount + 5'd1;
            end
          end else offs_next = offs + 4'd1;
          shift_next = shift - 32'd1;
          if (shift == 32'd1) phase_next = PH_SKIP;
        end
        default: ;
      endcase

      if (vb_left_next == 8'd0 && phase_next inside
          {PH_CDP_FIXED, PH_TC_SKIP, PH_CC_COUNT, PH_TRIPLES}) begin
        if (phase_next == PH_CDP_FIXED && offs_next < 4'd2) begin
          err_next = 1'b1; phase_next = PH_DONE;
        end else phase_next = PH_SKIP;
      end
      if (ab_left_next == 32'd0 && phase_next inside
          {PH_VANC_HDR, PH_CDP_FIXED, PH_TC_SKIP, PH_CC_COUNT, PH_TRIPLES, PH_SKIP}) begin
        if (phase_next == PH_VANC_HDR) begin
          err_next = 1'b1; phase_next = PH_DONE;
        end else if (captured_next) phase_next = PH_DONE;
        else begin
          pk_left_next = pk_left - 16'd1;
          if (pk_left == 16'd1) phase_next = PH_DONE;
          else begin
            phase_next = PH_HEADER; offs_next = '0; shift_next = '0;
          end
        end
      end
    end
  end

  // packet end outcome
  logic [1:0] end_status;
  always_comb begin
    if (err_next) end_status = StatusInvalid;
    else if (phase_next == PH_COUNT_HI || phase_next == PH_COUNT_LO) end_status = StatusNone;
    else if (phase_next == PH_DONE) end_status = captured_next ? StatusTriple : StatusNone;
    else end_status = StatusInvalid;
    if (end_status == StatusTriple && tcount_next == 5'd0) end_status = StatusNone;
  end

  ace_ram #(.Width(24), .Depth(TripleDepth), .Aw(TripleAw)) u_store (
    .clk     (clk),
    .wr_en   (take && ram_we),
    .wr_addr (tcount),
    .wr_data (tri_acc_next),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // parser registers, drain sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_COUNT_HI; offs <= '0; pk_left <= '0; ab_left <= '0;
      vb_left <= '0; shift <= '0; hline <= '0; hcoding <= '0;
      tcount <= '0; captured <= 1'b0; err <= 1'b0;
      mode <= MODE_PARSE; rd_idx <= '0; drain_n <= '0; out_valid <= 1'b0;
    end else begin
      // the emit step reloads the output itself
      if (out_valid && out_ready && mode != MODE_EMIT) out_valid <= 1'b0;
      case (mode)
        MODE_PARSE: begin
          if (take) begin
            tri_acc <= tri_acc_next;
            if (packet_end) begin
              phase <= PH_COUNT_HI; offs <= '0; pk_left <= '0; ab_left <= '0;
              vb_left <= '0; shift <= '0; hline <= '0; hcoding <= '0;
              tcount <= '0; captured <= 1'b0; err <= 1'b0;
              if (end_status == StatusTriple) begin
                mode <= MODE_READ; rd_idx <= '0; drain_n <= tcount_next;
              end else begin
                out_valid <= 1'b1; status <= end_status; cc_header <= '0;
                cc_byte_one <= '0; cc_byte_two <= '0; end_of_run <= 1'b1;
              end
            end else begin
              phase <= phase_next; offs <= offs_next; pk_left <= pk_left_next;
              ab_left <= ab_left_next; vb_left <= vb_left_next;
              shift <= shift_next; hline <= hline_next; hcoding <= hcoding_next;
              tcount <= tcount_next; captured <= captured_next; err <= err_next;
            end
          end
        end
        MODE_READ: mode <= MODE_EMIT;
        MODE_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1; status <= StatusTriple;
            cc_header <= rd_data[23:16]; cc_byte_one <= rd_data[15:8];
            cc_byte_two <= rd_data[7:0];
            end_of_run <= (rd_idx + 5'd1 == drain_n);
            if (rd_idx + 5'd1 == drain_n) mode <= MODE_PARSE;
            else begin
              rd_idx <= rd_idx + 5'd1; mode <= MODE_READ;
            end
          end
        end
        default: mode <= MODE_PARSE;
      endcase
    end
  end

endmodule

### hw/rtl/ace_checker.sv
// Port-level checker for the caption extractor, bound to the top level.
module ace_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] cc_header,
  input logic       end_of_run
);
  import ace_pkg::*;

  // status never takes the unused code
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == StatusTriple || status == StatusNone ||
                   status == StatusInvalid))
    else $error("bad status");

  // non-triple results carry a zero header and close the run
  a_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != StatusTriple) |-> (cc_header == 8'd0 && end_of_run))
    else $error("status result malformed");

  // no input taken while a result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted during output");

  // held result stays valid with a stable status
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)))
    else $error("result dropped");

endmodule

bind anc_caption_extractor_top ace_checker u_ace_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .cc_header(cc_header), .end_of_run(end_of_run)
);

### bench/tb_anc_caption_extractor_top.sv
// Self-checking bench for the ANC caption extractor: random and directed packets, scoreboard.
module tb_anc_caption_extractor_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ace_pkg::*;

  typedef struct packed {
    logic [1:0] st;
    logic [7:0] hdr;
    logic [7:0] one;
    logic [7:0] two;
    logic       eor;
  } cc_result_t;

  // parser phases of the predictor
  localparam int unsigned PhCountHi = 0, PhCountLo = 1, PhHeader = 2, PhVancHdr = 3;
  localparam int unsigned PhCdpFixed = 4, PhTcSkip = 5, PhCcCount = 6, PhTriples = 7;
  localparam int unsigned PhSkip = 8, PhDone = 9;
  localparam int unsigned FlagCaptured = 1, FlagError = 2;

  // payload build variants
  localparam int ModeGood = 0, ModeBadIdent = 1, ModeShortVanc = 2, ModeBigCc = 3;
  localparam int ModeZeroLen = 4;

  // Caption predictor plus queue of expected results
  class caption_scoreboard;
    int unsigned line_a, line_b, did_w, sdid_w;
    int unsigned phase, foff, pk_left, by_left, vb_left, shift, hline, hcoding;
    int unsigned tcount, flags;
    logic [23:0] store [TripleDepth];
    cc_result_t pending[$];
    int errors;

    function new();
      line_a = 9; line_b = 11; did_w = 8'h61; sdid_w = 1;
      errors = 0;
      clear();
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        RegLineFirst:  line_a = 32'(val);
        RegLineSecond: line_b = 32'(val);
        RegDid:        did_w = 32'(val[7:0]);
        RegSdid:       sdid_w = 32'(val[7:0]);
        default: ;
      endcase
    endfunction

    function void clear();
      phase = PhCountHi; foff = 0; pk_left = 0; by_left = 0; vb_left = 0;
      shift = 0; hline = 0; hcoding = 0; tcount = 0; flags = 0;
    endfunction

    function void fail();
      flags |= FlagError;
      phase = PhDone;
    endfunction

    function void next_anc();
      pk_left = (pk_left - 1) & 32'hFFFF;
      if (pk_left == 0) phase = PhDone;
      else begin
        phase = PhHeader; foff = 0; shift = 0;
      end
    endfunction

    function void anc_finished();
      if (phase == PhVancHdr) fail();
      else if (flags & FlagCaptured) phase = PhDone;
      else next_anc();
    endfunction

    function void header_done(int unsigned esize);
      if (esize != 1 || hcoding < 4 || hcoding > 12) fail();
      else if ((hcoding >= 7 && hcoding <= 9) || (hline != line_a && hline != line_b)) begin
        if (by_left == 0) next_anc();
        else phase = PhSkip;
      end else if (by_left == 0) fail();
      else begin
        phase = PhVancHdr; foff = 0; shift = 0;
      end
    endfunction

    function void take_section(int unsigned sec, bit allow_tc);
      if (allow_tc && sec == SecTimecode) begin
        phase = PhTcSkip; foff = 0;
      end else if (sec == SecCcData) phase = PhCcCount;
      else phase = PhSkip;
    endfunction

    function void payload_byte(logic [7:0] b);
      int unsigned ph;
      int unsigned cc;
      int unsigned sh;
      ph = phase;
      if (by_left > 0) by_left--;
      if (ph >= PhCdpFixed && ph <= PhTriples && vb_left > 0) vb_left--;
      case (ph)
        PhVancHdr: begin
          if (foff == 0) begin
            shift = 32'(b); foff = 1;
          end else if (foff == 1) begin
            shift = ((shift << 8) | b) & 32'hFFFF; foff = 2;
          end else begin
            if (by_left < b + 4) fail();
            else if ((shift >> 8) != did_w || (shift & 8'hFF) != sdid_w) phase = PhSkip;
            else if (b == 0) fail();
            else begin
              vb_left = 32'(b); phase = PhCdpFixed; foff = 0; shift = 0;
            end
          end
        end
        PhCdpFixed: begin
          if (foff == 0) shift = 32'(b);
          else if (foff == 1) begin
            shift = ((shift << 8) | b) & 32'hFFFF;
            if (shift != CdpIdent) fail();
          end else if (foff == 7) take_section(32'(b), 1'b1);
          if (phase == PhCdpFixed) foff++;
        end
        PhTcSkip: begin
          if (foff >= 4) take_section(32'(b), 1'b0);
          else foff++;
        end
        PhCcCount: begin
          cc = 32'(b & CcCountMask);
          if (vb_left < cc * 3) fail();
          else if (cc == 0) phase = PhSkip;
          else begin
            flags |= FlagCaptured; tcount = 0; foff = 0; shift = cc * 3;
            phase = PhTriples;
          end
        end
        PhTriples: begin
          if (tcount < TripleDepth) begin
            sh = 16 - 8 * foff;
            if (foff == 0) store[tcount] = {b, 16'h0};
            else store[tcount] = store[tcount] | (24'(b) << sh);
          end
          foff++;
          if (foff >= 3) begin
            foff = 0;
            if (tcount < TripleDepth) tcount++;
          end
          shift--;
          if (shift == 0) phase = PhSkip;
        end
        default: ;
      endcase
      ph = phase;
      if (vb_left == 0 && ph >= PhCdpFixed && ph <= PhTriples) begin
        if (ph == PhCdpFixed && foff < 2) fail();
        else phase = PhSkip;
      end
      ph = phase;
      if (by_left == 0 && ph >= PhVancHdr && ph <= PhSkip) anc_finished();
    endfunction

    function void take_byte(logic [7:0] b);
      case (phase)
        PhCountHi: begin
          shift = 32'(b); phase = PhCountLo;
        end
        PhCountLo: begin
          pk_left = ((shift << 8) | b) & 32'hFFFF;
          if (pk_left == 0) phase = PhDone;
          else begin
            phase = PhHeader; foff = 0; shift = 0;
          end
        end
        PhHeader: begin
          shift = (shift << 8) | b;
          if (foff == 1) hline = shift & 32'hFFFF;
          else if (foff == 3) hcoding = 32'(b);
          else if (foff == 9) by_left = shift;
          if (foff >= 13) header_done(shift);
          else foff++;
        end
        PhDone: ;
        default: payload_byte(b);
      endcase
    endfunction

    // one accepted input transaction
    function void note_input(logic [7:0] b, logic pe);
      logic [1:0] st;
      cc_result_t r;
      take_byte(b);
      if (!pe) return;
      if (flags & FlagError) st = StatusInvalid;
      else if (phase == PhCountHi || phase == PhCountLo) st = StatusNone;
      else if (phase == PhDone) st = (flags & FlagCaptured) ? StatusTriple : StatusNone;
      else st = StatusInvalid;
      if (st == StatusTriple && tcount > 0) begin
        for (int k = 0; k < tcount; k++) begin
          r.st = StatusTriple;
          r.hdr = store[k][23:16];
          r.one = store[k][15:8];
          r.two = store[k][7:0];
          r.eor = (k + 1 == tcount);
          pending.push_back(r);
        end
      end else begin
        r.st = (st == StatusTriple) ? StatusNone : st;
        r.hdr = 0; r.one = 0; r.two = 0; r.eor = 1'b1;
        pending.push_back(r);
      end
      clear();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // one accepted output transaction
    task check_result(cc_result_t a);
      cc_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result st=%0d", a.st));
        return;
      end
      e = pending.pop_front();
      if (a.st !== e.st) report($sformatf("status %0d, want %0d", a.st, e.st));
      if (a.hdr !== e.hdr) report($sformatf("cc_header %h, want %h", a.hdr, e.hdr));
      if (a.one !== e.one) report($sformatf("cc_byte_one %h, want %h", a.one, e.one));
      if (a.two !== e.two) report($sformatf("cc_byte_two %h, want %h", a.two, e.two));
      if (a.eor !== e.eor) report($sformatf("end_of_run %b, want %b", a.eor, e.eor));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        packet_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  status;
  logic [7:0]  cc_header, cc_byte_one, cc_byte_two;
  logic        end_of_run;

  caption_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int unsigned cur_line_a = 9, cur_line_b = 11, cur_did = 8'h61, cur_sdid = 1;
  logic [7:0] pkt[$];
  logic [7:0] pl[$];

  anc_caption_extractor_top dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .packet_end(packet_end), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .cc_header(cc_header),
    .cc_byte_one(cc_byte_one), .cc_byte_two(cc_byte_two), .end_of_run(end_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample handshakes mid-cycle; they complete at the next rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(data_byte, packet_end);
      if (out_valid && out_ready)
        sb.check_result({status, cc_header, cc_byte_one, cc_byte_two, end_of_run});
    end
  end

  // Result receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic pe);
    bit hit;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    packet_end <= pe;
    do begin
      @(negedge clk);
      hit = in_ready;
      @(posedge clk);
    end while (!hit);
  endtask

  // cut of zero sends the whole packet
  task automatic send_packet(input int cut);
    int n;
    n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
    for (int i = 0; i < n; i++) send_byte(pkt[i], i == n - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_cfg(input int unsigned la, lb, d, s);
    cur_line_a = la; cur_line_b = lb; cur_did = d; cur_sdid = s;
    cfg_write(RegLineFirst, 16'(la));
    cfg_write(RegLineSecond, 16'(lb));
    cfg_write(RegDid, 16'(d));
    cfg_write(RegSdid, 16'(s));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void push16(int unsigned v);
    pkt.push_back(v[15:8]); pkt.push_back(v[7:0]);
  endfunction

  function automatic void push32(int unsigned v);
    push16(v >> 16); push16(v);
  endfunction

  // VANC packet with caption distribution payload, into pl
  function automatic void build_cdp(int unsigned did, sdid, cc, bit tc, int unsigned sec,
                                    int mode);
    logic [7:0] c[$];
    int cc_at;
    int len;
    int rest;
    c = '{8'h96, 8'h69};
    if (mode == ModeBadIdent) c[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    repeat (5) c.push_back(8'($urandom));
    if (tc) begin
      c.push_back(SecTimecode);
      repeat (4) c.push_back(8'($urandom));
    end
    c.push_back(8'(sec));
    cc_at = c.size();
    c.push_back({3'($urandom), 5'(cc)});
    repeat (cc * 3) c.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) c.push_back(8'($urandom));
    if (mode == ModeBigCc) begin
      rest = c.size() - cc_at - 1;
      c[cc_at] = {3'($urandom), 5'(rest / 3 + 1)};
    end
    len = c.size();
    if (mode == ModeZeroLen) len = 0;
    if (mode == ModeShortVanc) len = c.size() + 1;
    pl = '{8'(did), 8'(sdid), 8'(len)};
    foreach (c[i]) pl.push_back(c[i]);
    repeat (4) pl.push_back(8'($urandom));
  endfunction

  function automatic void add_element(int unsigned line, coding, esize);
    push16(line);
    pkt.push_back(8'($urandom));
    pkt.push_back(8'(coding));
    push16($urandom);
    push32(pl.size());
    push32(esize);
    foreach (pl[i]) pkt.push_back(pl[i]);
  endfunction

  function automatic void start_packet(int unsigned count);
    pkt.delete();
    push16(count);
  endfunction

  function automatic int unsigned good_line();
    return $urandom_range(0, 1) ? cur_line_a : cur_line_b;
  endfunction

  function automatic int unsigned bad_line();
    int unsigned v;
    do v = $urandom_range(0, 3) ? $urandom_range(0, 20) : $urandom_range(0, 65535);
    while (v == cur_line_a || v == cur_line_b);
    return v;
  endfunction

  function automatic int unsigned good_coding();
    int unsigned v;
    v = $urandom_range(0, 5);
    return v < 3 ? v + 4 : v + 7;
  endfunction

  // Random packet of one element: mostly well formed, some broken, some noise
  function automatic int gen_random();
    int n_el;
    int kind;
    int unsigned cc;
    int cut;
    n_el = 1;
    start_packet($urandom_range(0, 15) == 0 ? $urandom_range(0, 65535) : n_el);
    for (int e = 0; e < n_el; e++) begin
      kind = $urandom_range(0, 9);
      cc = $urandom_range(0, 9) == 0 ? 31 : $urandom_range(1, 6);
      case (kind)
        0, 1, 2, 3, 4: begin
          build_cdp(cur_did, cur_sdid, cc, $urandom_range(0, 1), SecCcData, ModeGood);
          add_element(good_line(), good_coding(), 1);
        end
        5: begin
          build_cdp(cur_did, cur_sdid, cc, 0, SecCcData, ModeGood);
          add_element(bad_line(), good_coding(), 1);
        end
        6: begin
          build_cdp(cur_did, cur_sdid, cc, 0, SecCcData, ModeGood);
          add_element(good_line(), $urandom_range(7, 9), 1);
        end
        7: begin
          build_cdp(cur_did ^ $urandom_range(1, 255), $urandom_range(0, 1) ? cur_sdid
                    : cur_sdid ^ 1, cc, 0, SecCcData, ModeGood);
          add_element(good_line(), good_coding(), 1);
        end
        8: begin
          case ($urandom_range(0, 5))
            0: build_cdp(cur_did, cur_sdid, cc, 0, SecCcData, ModeBadIdent);
            1: build_cdp(cur_did, cur_sdid, cc, 0, SecCcData, ModeShortVanc);
            2: build_cdp(cur_did, cur_sdid, 2, 0, SecCcData, ModeBigCc);
            3: build_cdp(cur_did, cur_sdid, cc, 0, SecCcData, ModeZeroLen);
            4: build_cdp(cur_did, cur_sdid, cc, $urandom_range(0, 1), $urandom, ModeGood);
            default: build_cdp(cur_did, cur_sdid, 0, 0, SecCcData, ModeGood);
          endcase
          add_element(good_line(), good_coding(), 1);
        end
        default: begin
          pl.delete();
          repeat ($urandom_range(0, 8)) pl.push_back(8'($urandom));
          add_element($urandom_range(0, 1) ? good_line() : $urandom_range(0, 65535),
                      $urandom_range(0, 15), $urandom_range(0, 3) ? 1 : $urandom);
        end
      endcase
    end
    cut = 0;
    case ($urandom_range(0, 9))
      0: pkt[$urandom_range(0, pkt.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
      1: cut = $urandom_range(1, pkt.size() - 1);
      2: repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
      default: ;
    endcase
    return cut;
  endfunction

  task automatic random_packets(input int n);
    repeat (n) send_packet(gen_random());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-byte packet and a zero count
    pkt = '{8'h00}; send_packet(0);
    pkt = '{8'h00, 8'h00}; send_packet(0);
    // time code section with a full triple buffer
    start_packet(1); build_cdp(8'h61, 1, 31, 1, SecCcData, ModeGood);
    add_element(11, 12, 1); send_packet(0);
    // header cut off by packet end
    start_packet(1); push16(9); push16(16'h0004); send_packet(0);
    // coding out of range on an empty payload
    start_packet(1); pl.delete(); add_element(9, 13, 1); send_packet(0);

    // Long receiver hold-off while short packets keep coming
    wait_idle();
    hold_req = 1'b1;
    repeat (20) @(posedge clk);
    pkt = '{8'h00};
    repeat (4) send_packet(0);

    // Random packets under random register settings, then under the defaults
    wait_idle();
    apply_cfg($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 255),
              $urandom_range(0, 255));
    random_packets(1);
    wait_idle();
    apply_cfg(9, 11, 8'h61, 1);
    quiet = 1'b1;
    random_packets(2);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ace_pkg.sv
hw/rtl/ace_ram.sv
hw/rtl/anc_caption_extractor_top.sv
hw/rtl/ace_checker.sv
bench/tb_anc_caption_extractor_top.sv
